// ===== sv/lpsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency percentile statistics package
// Shared constants, register codes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package lpsu_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 32;

    localparam int RATIO_W   = 17;
    localparam int FRAC_W    = 16;
    localparam int OUT_W     = 32;
    localparam int IN_W      = 32;
    localparam int COUNT_W   = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RATIO  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_RATIO = 1'd1;

    localparam logic [RATIO_W-1:0] FIRST_RATIO_RST  = 17'd32768;
    localparam logic [RATIO_W-1:0] SECOND_RATIO_RST = 17'd62259;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // sample channel may take a beat
        logic sort_start; // outer sort index to one
        logic sort_read;  // fetch the next key
        logic sort_key;   // latch the key, fetch its left neighbour
        logic sort_shift; // move a larger entry one place right
        logic sort_place; // drop the key into its slot
        logic div_start;
        logic div_step;
        logic pct_mul;
        logic pct_ra;
        logic pct_rb;
        logic pct_rc;
        logic pct_add;
        logic max_rd;
        logic max_lat;
        logic res_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic acc_last;
        logic sort_done;
        logic j_one;
        logic gt;
        logic div_done;
        logic n_zero;
        logic pct_second;
        logic out_busy;
    } t_sts;

endpackage

// ===== sv/lpsu_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one latency sample per beat.
// ----------------------------------------------------------------------------
interface lpsu_in_if;
    logic                       valid;
    logic                       ready;
    logic [lpsu_pkg::IN_W-1:0]  sample_us;
    logic                       observed;
    logic                       last;

    modport source (output valid, sample_us, observed, last, input ready);
    modport sink   (input valid, sample_us, observed, last, output ready);
endinterface

// ===== sv/lpsu_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Summary channel
// Valid/ready channel carrying one statistics summary per beat.
// ----------------------------------------------------------------------------
interface lpsu_out_if;
    logic                          valid;
    logic                          ready;
    logic [lpsu_pkg::COUNT_W-1:0]  summary_count;
    logic [lpsu_pkg::OUT_W-1:0]    average_us;
    logic [lpsu_pkg::OUT_W-1:0]    first_percentile_us;
    logic [lpsu_pkg::OUT_W-1:0]    second_percentile_us;
    logic [lpsu_pkg::OUT_W-1:0]    maximum_us;
    logic                          overflow;

    modport source (output valid, summary_count, average_us, first_percentile_us,
                    second_percentile_us, maximum_us, overflow, input ready);
    modport sink   (input valid, summary_count, average_us, first_percentile_us,
                    second_percentile_us, maximum_us, overflow, output ready);
endinterface

// ===== sv/lpsu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/lpsu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Statistics controller
// Sequences loading, the in-place insertion sort, division and percentiles.
// ----------------------------------------------------------------------------
module lpsu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lpsu_pkg::t_sts i_sts,
    output lpsu_pkg::t_cmd o_cmd
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SI   = 4'd1;
    localparam logic [3:0] ST_SK   = 4'd2;
    localparam logic [3:0] ST_SC   = 4'd3;
    localparam logic [3:0] ST_SP   = 4'd4;
    localparam logic [3:0] ST_DIV  = 4'd5;
    localparam logic [3:0] ST_PMUL = 4'd6;
    localparam logic [3:0] ST_PRA  = 4'd7;
    localparam logic [3:0] ST_PRB  = 4'd8;
    localparam logic [3:0] ST_PRC  = 4'd9;
    localparam logic [3:0] ST_PAD  = 4'd10;
    localparam logic [3:0] ST_MXA  = 4'd11;
    localparam logic [3:0] ST_MXB  = 4'd12;
    localparam logic [3:0] ST_DONE = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = 1'b1;
                if (i_sts.acc_last) begin
                    o_cmd.sort_start = 1'b1;
                    n_state = ST_SI;
                end
            end
            ST_SI: begin
                if (i_sts.sort_done) begin
                    if (i_sts.n_zero) begin
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state = ST_DIV;
                    end
                end else begin
                    o_cmd.sort_read = 1'b1;
                    n_state = ST_SK;
                end
            end
            ST_SK: begin
                o_cmd.sort_key = 1'b1;
                n_state = ST_SC;
            end
            ST_SC: begin
                if (i_sts.gt) begin
                    o_cmd.sort_shift = 1'b1;
                    if (i_sts.j_one) begin
                        n_state = ST_SP;
                    end
                end else begin
                    n_state = ST_SP;
                end
            end
            ST_SP: begin
                o_cmd.sort_place = 1'b1;
                n_state = ST_SI;
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_PMUL;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_PMUL: begin
                o_cmd.pct_mul = 1'b1;
                n_state = ST_PRA;
            end
            ST_PRA: begin
                o_cmd.pct_ra = 1'b1;
                n_state = ST_PRB;
            end
            ST_PRB: begin
                o_cmd.pct_rb = 1'b1;
                n_state = ST_PRC;
            end
            ST_PRC: begin
                o_cmd.pct_rc = 1'b1;
                n_state = ST_PAD;
            end
            ST_PAD: begin
                o_cmd.pct_add = 1'b1;
                n_state = i_sts.pct_second ? ST_MXA : ST_PMUL;
            end
            ST_MXA: begin
                o_cmd.max_rd = 1'b1;
                n_state = ST_MXB;
            end
            ST_MXB: begin
                o_cmd.max_lat = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

// ===== sv/lpsu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Statistics datapath
// Sample store, totals, sort pointers, divider, interpolation and summary.
// ----------------------------------------------------------------------------
module lpsu_dp #(
    parameter int MAX_SAMPLES = lpsu_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = lpsu_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lpsu_pkg::t_cmd                    i_cmd,
    output lpsu_pkg::t_sts                    o_sts,
    input  logic                              i_cfg_we,
    input  logic [lpsu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lpsu_pkg::RATIO_W-1:0]      i_cfg_data,
    lpsu_in_if.sink                           i_sample,
    lpsu_out_if.source                        o_result
);
    localparam int ADDR_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int TOT_W  = SAMPLE_BITS + CNT_W;
    localparam int DCNT_W = $clog2(TOT_W + 1);
    localparam int POS_W  = CNT_W + lpsu_pkg::RATIO_W;
    localparam int FW     = lpsu_pkg::FRAC_W;
    localparam int PROD_W = FW + SAMPLE_BITS;

    logic [lpsu_pkg::RATIO_W-1:0] r_ratio1, r_ratio2;
    logic [CNT_W-1:0]       r_count, r_i, r_j, r_lo;
    logic [TOT_W-1:0]       r_total, r_dq;
    logic                   r_drop, r_sel, r_full;
    logic [SAMPLE_BITS-1:0] r_key, r_a, r_pct0, r_pct1, r_max;
    logic [CNT_W-1:0]       r_rem;
    logic [DCNT_W-1:0]      r_dcnt;
    logic [POS_W-1:0]       r_pos;
    logic [FW-1:0]          r_frac;
    logic [PROD_W-1:0]      r_prod;
    logic                   r_ovalid;

    logic                   acc, store;
    logic [SAMPLE_BITS-1:0] sample, rd, b_val;
    logic                   we;
    logic [ADDR_W-1:0]      waddr, raddr;
    logic [SAMPLE_BITS-1:0] wdata;
    logic [CNT_W-1:0]       n_m1, lo_c;
    logic [FW-1:0]          frac_c;
    logic [lpsu_pkg::RATIO_W-1:0] ratio;
    logic [CNT_W:0]         trial;
    logic                   ge;

    assign sample = SAMPLE_BITS'(i_sample.sample_us);
    assign acc    = i_sample.valid && i_cmd.accept;
    assign store  = acc && i_sample.observed && (r_count < CNT_W'(MAX_SAMPLES));
    assign i_sample.ready = i_cmd.accept;

    assign n_m1   = r_count - CNT_W'(1);
    assign ratio  = r_sel ? r_ratio2 : r_ratio1;
    assign lo_c   = r_full ? n_m1 : r_pos[FW +: CNT_W];
    assign frac_c = r_full ? '0 : r_pos[FW-1:0];
    assign b_val  = (r_frac == '0) ? r_a : rd;
    assign trial  = {r_rem, r_dq[TOT_W-1]};
    assign ge     = trial >= {1'b0, r_count};

    always_comb begin
        we    = 1'b0;
        waddr = r_count[ADDR_W-1:0];
        wdata = sample;
        raddr = n_m1[ADDR_W-1:0];
        priority if (store) begin
            we = 1'b1;
        end else if (i_cmd.sort_shift) begin
            we    = 1'b1;
            waddr = r_j[ADDR_W-1:0];
            wdata = rd;
        end else if (i_cmd.sort_place) begin
            we    = 1'b1;
            waddr = r_j[ADDR_W-1:0];
            wdata = r_key;
        end
        priority if (i_cmd.sort_read) begin
            raddr = r_i[ADDR_W-1:0];
        end else if (i_cmd.sort_key) begin
            raddr = ADDR_W'(r_i - CNT_W'(1));
        end else if (i_cmd.sort_shift) begin
            raddr = ADDR_W'(r_j - CNT_W'(2));
        end else if (i_cmd.pct_ra) begin
            raddr = lo_c[ADDR_W-1:0];
        end else if (i_cmd.pct_rb) begin
            raddr = ADDR_W'(r_lo + CNT_W'(1));
        end else if (i_cmd.max_rd) begin
            raddr = n_m1[ADDR_W-1:0];
        end
    end

    lpsu_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio1 <= lpsu_pkg::FIRST_RATIO_RST;
            r_ratio2 <= lpsu_pkg::SECOND_RATIO_RST;
            r_count  <= '0;
            r_total  <= '0;
            r_drop   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == lpsu_pkg::CFG_FIRST_RATIO) begin
                r_ratio1 <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == lpsu_pkg::CFG_SECOND_RATIO) begin
                r_ratio2 <= i_cfg_data;
            end
            if (store) begin
                r_count <= r_count + CNT_W'(1);
                r_total <= r_total + TOT_W'(sample);
            end else if (acc && i_sample.observed) begin
                r_drop <= 1'b1;
            end
            if (i_cmd.res_load) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working registers of the summary pass.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_start) r_i <= CNT_W'(1);
        if (i_cmd.sort_place) r_i <= r_i + CNT_W'(1);
        if (i_cmd.sort_key) begin
            r_key <= rd;
            r_j   <= r_i;
        end
        if (i_cmd.sort_shift) r_j <= r_j - CNT_W'(1);
        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_dq   <= r_total;
            r_dcnt <= DCNT_W'(TOT_W);
            r_sel  <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= ge ? CNT_W'(trial - {1'b0, r_count}) : trial[CNT_W-1:0];
            r_dq   <= {r_dq[TOT_W-2:0], ge};
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
        if (i_cmd.pct_mul) begin
            r_pos  <= POS_W'(n_m1) * POS_W'(ratio);
            r_full <= ratio[lpsu_pkg::RATIO_W-1];
        end
        if (i_cmd.pct_ra) begin
            r_lo   <= lo_c;
            r_frac <= frac_c;
        end
        if (i_cmd.pct_rb) r_a <= rd;
        if (i_cmd.pct_rc) r_prod <= PROD_W'(r_frac) * PROD_W'(b_val - r_a);
        if (i_cmd.pct_add) begin
            if (r_sel) r_pct1 <= r_a + r_prod[FW +: SAMPLE_BITS];
            else       r_pct0 <= r_a + r_prod[FW +: SAMPLE_BITS];
            r_sel <= ~r_sel;
        end
        if (i_cmd.max_lat) r_max <= rd;
        if (i_cmd.res_load) begin
            o_result.overflow <= r_drop;
            if (r_count == '0) begin
                o_result.summary_count        <= '0;
                o_result.average_us           <= '0;
                o_result.first_percentile_us  <= '0;
                o_result.second_percentile_us <= '0;
                o_result.maximum_us           <= '0;
            end else begin
                o_result.summary_count        <= lpsu_pkg::COUNT_W'(r_count);
                o_result.average_us           <= lpsu_pkg::OUT_W'(r_dq);
                o_result.first_percentile_us  <= lpsu_pkg::OUT_W'(r_pct0);
                o_result.second_percentile_us <= lpsu_pkg::OUT_W'(r_pct1);
                o_result.maximum_us           <= lpsu_pkg::OUT_W'(r_max);
            end
        end
    end

    assign o_result.valid = r_ovalid;

    assign o_sts.acc_last   = acc && i_sample.last;
    assign o_sts.sort_done  = r_i >= r_count;
    assign o_sts.j_one      = r_j == CNT_W'(1);
    assign o_sts.gt         = rd > r_key;
    assign o_sts.div_done   = r_dcnt == '0;
    assign o_sts.n_zero     = r_count == '0;
    assign o_sts.pct_second = r_sel;
    assign o_sts.out_busy   = r_ovalid;
endmodule

// ===== sv/latency_percentile_statistics_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency percentile statistics unit
// Collects latency samples and gives count, mean, two percentiles and maximum.
// ----------------------------------------------------------------------------
// Usage. Samples arrive on i_sample, one beat per cycle while the unit is
// loading. A beat with observed set is written to the sample store; once the
// store holds MAX_SAMPLES entries further observed samples are dropped and the
// overflow flag is set. A beat with last set starts a summary pass, and the
// sample channel holds ready low until that summary sits in the output
// register. The pass sorts the store in place by insertion sort, one compare
// per cycle on the single read port of the store, then divides the running
// total by the count bit-serially, then computes the two interpolated
// percentiles and the maximum and loads the summary. The summary beat waits
// in the output register on o_result; new samples are accepted while it
// waits, but a following summary pass stalls before loading its summary until
// the receiver has taken it. The user must write the ratios through the
// configuration port only while idle; the block does not enforce this. Reset
// clears the count, total and overflow flag and restores the default ratios;
// the store itself is not cleared.
// ----------------------------------------------------------------------------
module latency_percentile_statistics_unit #(
    parameter int MAX_SAMPLES = lpsu_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = lpsu_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lpsu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lpsu_pkg::RATIO_W-1:0]   i_cfg_data,
    lpsu_in_if.sink                        i_sample,
    lpsu_out_if.source                     o_result
);
    lpsu_pkg::t_cmd cmd;
    lpsu_pkg::t_sts sts;

    // The controller only issues commands; all storage lives in the datapath.
    lpsu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lpsu_dp #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (i_sample),
        .o_result   (o_result)
    );

    // A summary request closes the sample channel on the next cycle.
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready && i_sample.last) |=> !i_sample.ready)
        else $error("sample channel still open after a summary request");

    // Loading the summary always presents a beat on the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |=> o_result.valid)
        else $error("summary load did not raise the output beat");

    // A summary is never loaded over one the receiver has not yet taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |-> !o_result.valid)
        else $error("summary loaded over a pending beat");

    // An empty summary reports zero for its mean and maximum.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MAX_SAMPLES < 2048 && o_result.valid && o_result.summary_count == '0)
        |-> (o_result.average_us == '0 && o_result.maximum_us == '0))
        else $error("empty summary carries non-zero values");
endmodule
